// File: rtl/itde_pkg.sv
// Shared types and constants for the inode table directory engine.
// No dependencies; every other rtl file except itde_ram refers to this package by scoped names.
`default_nettype none
package itde_pkg;

    localparam int ACT_W    = 3;
    localparam int IDX_W    = 6;
    localparam int NAME_W   = 64;
    localparam int IN_W     = 80;
    localparam int OUT_W    = 16;
    localparam int SCAN_W   = 16;

    localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESET  = 3'd4;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FILE = 2'd1;
    localparam logic [1:0] KIND_DIR  = 2'd2;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // Classified command handed from the front end to the executor
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              node_kind;
        logic [IDX_W-1:0]  inode_index;
        logic [IDX_W-1:0]  sub_index;
        logic [NAME_W-1:0] entry_name;
        logic              act_ok;
        logic              idx_ok;
        logic              sub_ok;
        logic              name_ok;
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/inode_table_directory_engine_core.sv
// Top level of the inode table directory engine: front end, command queue, executor.
// Depends on itde_pkg, itde_front, itde_queue, itde_back (and itde_ram below it).
//
//  channel  | dir | tdata bits, lowest first
//  ---------+-----+----------------------------------------------------------
//  s (in)   | in  | action[3] node_kind[1] inode_index[6] sub_index[6] entry_name[64]
//  m (out)  | out | status[1] new_index[6] kind_read[2], zero pad to 16
//
// Add takes no longer than get and delete.
// Create scans the live map 16 inodes per cycle.
// Reset entry walks the directory through the slot memory, one slot per cycle.
// The queue keeps taking items while the executor or the output register is stalled,
// until it is full. Reset marks every inode free at once.
`default_nettype none
module inode_table_directory_engine_core #(
    parameter int INODE_COUNT   = 64,
    parameter int SLOTS_PER_DIR = 16,
    parameter int QUEUE_DEPTH   = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    // action, node_kind, inode_index, sub_index, entry_name
    input  wire logic [itde_pkg::IN_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    // status, new_index, kind_read, zero pad
    output logic [itde_pkg::OUT_W-1:0]      o_m_tdata
);

    itde_pkg::t_cmd front_cmd;
    itde_pkg::t_cmd head_cmd;
    logic           front_valid;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    itde_front #(.INODE_COUNT(INODE_COUNT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_valid    (front_valid),
        .o_cmd      (front_cmd),
        .i_ready    (!q_full)
    );

    itde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    itde_back #(
        .INODE_COUNT   (INODE_COUNT),
        .SLOTS_PER_DIR (SLOTS_PER_DIR)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_cmd      (head_cmd),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/itde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module itde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/itde_front.sv
// Front end: takes input transfers, unpacks and range-checks them into a t_cmd.
// Depends on itde_pkg.
`default_nettype none
module itde_front #(
    parameter int INODE_COUNT = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [itde_pkg::IN_W-1:0] i_s_tdata,
    output logic                           o_valid,
    output itde_pkg::t_cmd                 o_cmd,
    input  wire logic                      i_ready
);

    localparam int CMP_W = (($clog2(INODE_COUNT) > itde_pkg::IDX_W) ?
                            $clog2(INODE_COUNT) : itde_pkg::IDX_W) + 1;

    logic           r_valid;
    itde_pkg::t_cmd r_cmd;
    itde_pkg::t_cmd n_cmd;
    logic           accept;

    always_comb begin
        n_cmd.action      = i_s_tdata[2:0];
        n_cmd.node_kind   = i_s_tdata[3];
        n_cmd.inode_index = i_s_tdata[9:4];
        n_cmd.sub_index   = i_s_tdata[15:10];
        n_cmd.entry_name  = i_s_tdata[79:16];
        n_cmd.act_ok      = (n_cmd.action == itde_pkg::ACT_CREATE) ||
                            (n_cmd.action == itde_pkg::ACT_DELETE) ||
                            (n_cmd.action == itde_pkg::ACT_GET)    ||
                            (n_cmd.action == itde_pkg::ACT_ADD)    ||
                            (n_cmd.action == itde_pkg::ACT_RESET);
        n_cmd.idx_ok      = CMP_W'(n_cmd.inode_index) < CMP_W'(INODE_COUNT);
        n_cmd.sub_ok      = CMP_W'(n_cmd.sub_index) < CMP_W'(INODE_COUNT);
        // empty name: lowest byte zero
        n_cmd.name_ok     = |n_cmd.entry_name[7:0];
    end

    assign o_s_tready = !r_valid || i_ready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule
`default_nettype wire

// File: rtl/itde_queue.sv
// Short command queue between the front end and the executor.
// Depends on itde_pkg.
`default_nettype none
module itde_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire itde_pkg::t_cmd i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output itde_pkg::t_cmd      o_data,
    output logic                o_empty
);

    localparam int PW = $clog2(DEPTH);

    itde_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [PW:0]    r_count;
    logic           push;
    logic           pop;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/itde_back.sv
// Executor: runs one command at a time against the inode and slot stores,
// holds the result in the output register. Depends on itde_pkg, itde_ram.
`default_nettype none
module itde_back #(
    parameter int INODE_COUNT   = 64,
    parameter int SLOTS_PER_DIR = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_empty,
    input  wire itde_pkg::t_cmd             i_cmd,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [itde_pkg::OUT_W-1:0]      o_m_tdata
);

    localparam int IW      = $clog2(INODE_COUNT);
    localparam int SW      = (SLOTS_PER_DIR > 1) ? $clog2(SLOTS_PER_DIR) : 1;
    localparam int EDEPTH  = INODE_COUNT * SLOTS_PER_DIR;
    localparam int EAW     = $clog2(EDEPTH);
    localparam int EW      = itde_pkg::NAME_W + itde_pkg::IDX_W;
    localparam int SCW     = itde_pkg::SCAN_W;
    localparam int ZW      = $clog2(SCW);
    localparam int NCHUNK  = (INODE_COUNT + SCW - 1) / SCW;
    localparam int CW      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PADW    = NCHUNK * SCW;
    localparam int GW      = CW + ZW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]               r_state,  n_state;
    itde_pkg::t_cmd           r_cmd,    n_cmd;
    logic [INODE_COUNT-1:0]   r_live,   n_live;
    logic [CW-1:0]            r_chunk,  n_chunk;
    logic [SW:0]              r_slot,   n_slot;
    logic                     r_prev_valid, n_prev_valid;
    logic [SW-1:0]            r_prev_slot,  n_prev_slot;
    logic [SLOTS_PER_DIR-1:0] r_used,   n_used;
    logic [EAW-1:0]           r_base,   n_base;
    logic                     r_res_status, n_res_status;
    logic [itde_pkg::IDX_W-1:0] r_res_new, n_res_new;
    logic [1:0]               r_res_kind, n_res_kind;
    logic                     r_out_valid;
    logic                     r_out_status;
    logic [itde_pkg::IDX_W-1:0] r_out_new;
    logic [1:0]               r_out_kind;

    logic                     kind_we;
    logic [IW-1:0]            kind_waddr;
    logic                     kind_wdata;
    logic [IW-1:0]            kind_raddr;
    logic                     kind_rdata;
    logic                     used_we;
    logic [IW-1:0]            used_waddr;
    logic [SLOTS_PER_DIR-1:0] used_wdata;
    logic [IW-1:0]            used_raddr;
    logic [SLOTS_PER_DIR-1:0] used_rdata;
    logic                     ent_we;
    logic [EAW-1:0]           ent_waddr;
    logic [EW-1:0]            ent_wdata;
    logic [EAW-1:0]           ent_raddr;
    logic [EW-1:0]            ent_rdata;

    logic [IW-1:0]            idx_t;
    logic [IW-1:0]            sub_t;
    logic                     live_idx;
    logic                     live_sub;
    logic [PADW-1:0]          live_pad;
    logic [SCW-1:0]           chunk_bits;
    logic                     zfound;
    logic [ZW-1:0]            zpos;
    logic [GW-1:0]            gidx;
    logic                     ffound;
    logic [SW-1:0]            fpos;
    logic                     hit;
    logic                     out_load;

    itde_ram #(.WIDTH(1), .DEPTH(INODE_COUNT)) u_kind_ram (
        .i_clk   (i_clk),
        .i_we    (kind_we),
        .i_waddr (kind_waddr),
        .i_wdata (kind_wdata),
        .i_raddr (kind_raddr),
        .o_rdata (kind_rdata)
    );

    itde_ram #(.WIDTH(SLOTS_PER_DIR), .DEPTH(INODE_COUNT)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (used_raddr),
        .o_rdata (used_rdata)
    );

    // slot entry: name above, target index in the low bits
    itde_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // pad the live map with busy bits up to whole scan chunks
    for (genvar k = 0; k < PADW; k++) begin : g_pad
        if (k < INODE_COUNT) begin : g_real
            assign live_pad[k] = r_live[k];
        end else begin : g_fill
            assign live_pad[k] = 1'b1;
        end
    end

    assign idx_t      = IW'(r_cmd.inode_index);
    assign sub_t      = IW'(r_cmd.sub_index);
    assign live_idx   = r_cmd.idx_ok && r_live[idx_t];
    assign live_sub   = r_cmd.sub_ok && r_live[sub_t];
    assign chunk_bits = live_pad[r_chunk*SCW +: SCW];
    assign gidx       = {r_chunk, zpos};
    assign hit        = r_prev_valid && r_used[r_prev_slot] &&
                        (ent_rdata[itde_pkg::IDX_W-1:0] == r_cmd.sub_index);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    // lowest free inode in the current chunk
    always_comb begin
        zfound = 1'b0;
        zpos   = '0;
        for (int j = SCW - 1; j >= 0; j--) begin
            if (!chunk_bits[j]) begin
                zfound = 1'b1;
                zpos   = ZW'(j);
            end
        end
    end

    // lowest free slot of the directory just read
    always_comb begin
        ffound = 1'b0;
        fpos   = '0;
        for (int j = SLOTS_PER_DIR - 1; j >= 0; j--) begin
            if (!used_rdata[j]) begin
                ffound = 1'b1;
                fpos   = SW'(j);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_live       = r_live;
        n_chunk      = r_chunk;
        n_slot       = r_slot;
        n_prev_valid = r_prev_valid;
        n_prev_slot  = r_prev_slot;
        n_used       = r_used;
        n_base       = r_base;
        n_res_status = r_res_status;
        n_res_new    = r_res_new;
        n_res_kind   = r_res_kind;
        o_pop        = 1'b0;
        kind_we      = 1'b0;
        kind_waddr   = IW'(gidx);
        kind_wdata   = r_cmd.node_kind;
        kind_raddr   = idx_t;
        used_we      = 1'b0;
        used_waddr   = idx_t;
        used_wdata   = '0;
        used_raddr   = idx_t;
        ent_we       = 1'b0;
        ent_waddr    = r_base + EAW'(fpos);
        ent_wdata    = {r_cmd.entry_name, r_cmd.sub_index};
        ent_raddr    = r_base + EAW'(r_slot);

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop        = 1'b1;
                    n_cmd        = i_cmd;
                    n_res_status = itde_pkg::ST_FAIL;
                    n_res_new    = '0;
                    n_res_kind   = itde_pkg::KIND_NONE;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                n_base  = EAW'(idx_t) * EAW'(SLOTS_PER_DIR);
                n_chunk = '0;
                if (!r_cmd.act_ok) begin
                    n_state = S_OUT;
                end else if (r_cmd.action == itde_pkg::ACT_CREATE) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_SCAN: begin
                if (zfound) begin
                    n_live[IW'(gidx)] = 1'b1;
                    kind_we           = 1'b1;
                    used_we           = 1'b1;
                    used_waddr        = IW'(gidx);
                    n_res_status      = itde_pkg::ST_OK;
                    n_res_new         = itde_pkg::IDX_W'(gidx);
                    n_state           = S_OUT;
                end else if (r_chunk == CW'(NCHUNK - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            S_EVAL: begin
                n_state = S_OUT;
                case (r_cmd.action)
                    itde_pkg::ACT_DELETE: begin
                        if (live_idx) begin
                            n_live[idx_t] = 1'b0;
                            n_res_status  = itde_pkg::ST_OK;
                        end
                    end
                    itde_pkg::ACT_GET: begin
                        if (live_idx) begin
                            n_res_status = itde_pkg::ST_OK;
                            n_res_kind   = kind_rdata ? itde_pkg::KIND_DIR
                                                      : itde_pkg::KIND_FILE;
                        end
                    end
                    itde_pkg::ACT_ADD: begin
                        if (live_idx && kind_rdata && live_sub && r_cmd.name_ok &&
                            ffound) begin
                            used_we      = 1'b1;
                            used_wdata   = used_rdata |
                                           (SLOTS_PER_DIR'(1) << fpos);
                            ent_we       = 1'b1;
                            n_res_status = itde_pkg::ST_OK;
                        end
                    end
                    itde_pkg::ACT_RESET: begin
                        if (live_idx && kind_rdata && live_sub) begin
                            n_used       = used_rdata;
                            n_slot       = '0;
                            n_prev_valid = 1'b0;
                            n_state      = S_WALK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                // issue one slot read per cycle, compare the one read last cycle
                if (hit) begin
                    used_we      = 1'b1;
                    used_wdata   = r_used & ~(SLOTS_PER_DIR'(1) << r_prev_slot);
                    n_res_status = itde_pkg::ST_OK;
                    n_state      = S_OUT;
                end else if (r_slot == (SW+1)'(SLOTS_PER_DIR)) begin
                    n_prev_valid = 1'b0;
                    if (!r_prev_valid) begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_prev_valid = 1'b1;
                    n_prev_slot  = SW'(r_slot);
                    n_slot       = r_slot + 1'b1;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_chunk      <= n_chunk;
        r_slot       <= n_slot;
        r_prev_valid <= n_prev_valid;
        r_prev_slot  <= n_prev_slot;
        r_used       <= n_used;
        r_base       <= n_base;
        r_res_status <= n_res_status;
        r_res_new    <= n_res_new;
        r_res_kind   <= n_res_kind;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_new    <= r_res_new;
            r_out_kind   <= r_res_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = itde_pkg::OUT_W'({r_out_kind, r_out_new, r_out_status});

endmodule
`default_nettype wire
